/* rtl/core/iplpm_pkg.sv */
`default_nettype none
package iplpm_pkg;
  localparam int TableDepthDef = 16;
  localparam int GatewayCountDef = 16;
  localparam int AddrW = 128;
  localparam int PlenW = 8;
  localparam int GwW = 4;
  localparam int StW = 2;
  localparam logic [PlenW-1:0] FullPrefix = 8'd128;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_UPDATE = 2'd3
  } req_t;

  typedef enum logic [StW-1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_COVERED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t              req;
    logic [AddrW-1:0]  addr;
    logic [PlenW-1:0]  plen;
    logic [GwW-1:0]    gw;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [GwW-1:0]    gw;
    logic [PlenW-1:0]  len;
  } rsp_t;

  function automatic logic [AddrW-1:0] prefix_mask(input logic [PlenW-1:0] p);
    logic [AddrW-1:0] m;
    m = '0;
    for (int i = 0; i < AddrW; i++) begin
      m[AddrW-1-i] = (i < int'(p));
    end
    return m;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ipv6_longest_prefix_route_table_core.sv */
`default_nettype none
// Channel | Dir | tdata fields (low bit up)                         | tuser
// in_     | in  | addr_hi[63:0] addr_lo[127:64] prefix_len[135:128]  | req_type[1:0]
//         |     | gateway[139:136], zero pad to 144                  |
// out_    | out | status[1:0] out_gateway[5:2] matched_len[13:6] pad | -
// Each request scans the whole table in the back end, one table-RAM read per
// cycle, then a final compare step, write-back and result.
// A two-entry queue accepts requests while the back end scans.
// rst_n synchronous active low empties the table at once (valid bits only).
// A stalled result holds the back end; the queue fills, then in_tready drops.
module ipv6_longest_prefix_route_table_core #(
  parameter int TABLE_DEPTH   = iplpm_pkg::TableDepthDef,
  parameter int GATEWAY_COUNT = iplpm_pkg::GatewayCountDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,  // addr_hi, addr_lo, prefix_len, gateway
  input  wire logic [1:0]   in_tuser,  // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata  // status, out_gateway, matched_len
);
  import iplpm_pkg::*;
  cmd_t q_data;
  logic q_valid, q_pop;
  rsp_t rsp;

  iplpm_front #(.GatewayCount(GATEWAY_COUNT)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .req(in_tuser),
    .addr({in_tdata[63:0], in_tdata[127:64]}),
    .plen(in_tdata[135:128]), .gw(in_tdata[139:136]),
    .q_data, .q_valid, .q_pop
  );

  iplpm_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop,
    .rsp_valid(out_tvalid), .rsp_ready(out_tready), .rsp
  );

  assign out_tdata = {2'b00, rsp.len, rsp.gw, rsp.status};
endmodule
`default_nettype wire

/* rtl/core/iplpm_ram.sv */
`default_nettype none
module iplpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/iplpm_front.sv */
`default_nettype none
module iplpm_front #(
  parameter int GatewayCount = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       req,
  input  wire logic [127:0]     addr,
  input  wire logic [7:0]       plen,
  input  wire logic [3:0]       gw,
  output iplpm_pkg::cmd_t       q_data,
  output logic                  q_valid,
  input  wire logic             q_pop
);
  import iplpm_pkg::*;
  // two-entry queue
  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  cmd_t c;
  logic push;

  always_comb begin
    c.req  = req_t'(req);
    c.addr = addr;
    c.plen = (plen > FullPrefix) ? FullPrefix : plen;
    c.gw   = (32'(gw) >= GatewayCount) ? GwW'(GatewayCount - 1) : gw;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (q_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
    if (push) begin
      q_r[wr_r] <= c;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> (cnt_r == 2'd2))
    else $error("queue count lost");
endmodule
`default_nettype wire

/* rtl/core/iplpm_back.sv */
`default_nettype none
module iplpm_back #(
  parameter int TableDepth = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire iplpm_pkg::cmd_t  q_data,
  input  wire logic             q_valid,
  output logic                  q_pop,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output iplpm_pkg::rsp_t       rsp
);
  import iplpm_pkg::*;
  localparam int IdxW = $clog2(TableDepth);
  localparam int EntW = AddrW + PlenW + GwW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WRITE, S_OUT} state_t;
  state_t state_r;

  logic [TableDepth-1:0] valid_r;
  cmd_t                  cmd_r;
  logic [IdxW:0]         idx_r;
  logic [IdxW-1:0]       cur_r;
  logic                  cur_v_r;
  logic                  lm_hit_r, ex_hit_r, free_hit_r;
  logic [IdxW-1:0]       ex_idx_r, free_idx_r;
  logic [PlenW-1:0]      lm_len_r;
  logic [GwW-1:0]        lm_gw_r;
  rsp_t                  rsp_r;

  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [EntW-1:0]       wdata, rdata;
  logic [AddrW-1:0]      e_addr;
  logic [PlenW-1:0]      e_plen;
  logic [GwW-1:0]        e_gw;
  logic                  lm_m, ex_m;

  iplpm_ram #(.Width(EntW), .Depth(TableDepth)) u_ram (
    .clk, .we, .waddr, .wdata,
    .raddr(idx_r[IdxW-1:0]), .rdata
  );

  assign {e_addr, e_plen, e_gw} = rdata;
  assign lm_m = cur_v_r && ((cmd_r.addr & prefix_mask(e_plen)) == e_addr);
  assign ex_m = cur_v_r && (e_plen == cmd_r.plen) && (e_addr == cmd_r.addr);

  always_comb begin
    we    = 1'b0;
    waddr = free_idx_r;
    wdata = {cmd_r.addr, cmd_r.plen, cmd_r.gw};
    if (state_r == S_WRITE) begin
      if (cmd_r.req == REQ_ADD && !lm_hit_r && free_hit_r) begin
        we = 1'b1;
      end else if (cmd_r.req == REQ_UPDATE && ex_hit_r) begin
        we    = 1'b1;
        waddr = ex_idx_r;
        wdata = {cmd_r.addr, cmd_r.plen, cmd_r.gw};
      end
    end
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign rsp_valid = (state_r == S_OUT);
  assign rsp       = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      cur_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r      <= q_data;
            idx_r      <= '0;
            lm_hit_r   <= 1'b0;
            ex_hit_r   <= 1'b0;
            free_hit_r <= 1'b0;
            cur_v_r    <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          // compare entry read last cycle; in S_SCAN advance read pointer
          if (lm_m && (!lm_hit_r || e_plen > lm_len_r)) begin
            lm_hit_r <= 1'b1;
            lm_len_r <= e_plen;
            lm_gw_r  <= e_gw;
          end
          if (ex_m && !ex_hit_r) begin
            ex_hit_r <= 1'b1;
            ex_idx_r <= cur_r;
          end
          if (state_r == S_SCAN) begin
            cur_r   <= idx_r[IdxW-1:0];
            cur_v_r <= valid_r[idx_r[IdxW-1:0]];
            if (!valid_r[idx_r[IdxW-1:0]] && !free_hit_r) begin
              free_hit_r <= 1'b1;
              free_idx_r <= idx_r[IdxW-1:0];
            end
            if (idx_r == (IdxW+1)'(TableDepth - 1)) begin
              state_r <= S_LAST;
            end
            idx_r <= idx_r + (IdxW+1)'(1);
          end else begin
            cur_v_r <= 1'b0;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          rsp_r.gw  <= (cmd_r.req == REQ_LOOKUP && lm_hit_r) ? lm_gw_r : '0;
          rsp_r.len <= (cmd_r.req == REQ_LOOKUP && lm_hit_r) ? lm_len_r : '0;
          unique case (cmd_r.req)
            REQ_LOOKUP: begin
              rsp_r.status <= lm_hit_r ? ST_OK : ST_NOMATCH;
            end
            REQ_ADD: begin
              if (lm_hit_r) begin
                rsp_r.status <= ST_COVERED;
              end else if (free_hit_r) begin
                rsp_r.status <= ST_OK;
                valid_r[free_idx_r] <= 1'b1;
              end else begin
                rsp_r.status <= ST_FULL;
              end
            end
            REQ_REMOVE: begin
              if (ex_hit_r) begin
                rsp_r.status <= ST_OK;
                valid_r[ex_idx_r] <= 1'b0;
              end else begin
                rsp_r.status <= ST_NOMATCH;
              end
            end
            REQ_UPDATE: begin
              rsp_r.status <= ex_hit_r ? ST_OK : ST_NOMATCH;
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) we |-> state_r == S_WRITE)
    else $error("table write outside write-back");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !rsp_ready) |=> (state_r == S_OUT && $stable(rsp_r)))
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_SCAN)
    else $error("pop did not start scan");
endmodule
`default_nettype wire
